/* src/assert_macros.svh */
// Assertion macros for the RTL checks; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

/* src/scpf_pkg.sv */
// Types and constants for the servo command packet framer.
`default_nettype none
package scpf_pkg;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] HDR_FIRST  = 8'hFA;
    localparam logic [7:0] HDR_SECOND = 8'hAF;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } t_op;

    typedef struct packed {
        logic       op;
        logic [7:0] packet_id;
        logic [7:0] flags;
        logic [7:0] address;
        logic [7:0] length_byte;
        logic [7:0] servo_count;
        logic [7:0] first_id;
        logic [7:0] data_byte;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } t_res;

    typedef logic [MAX_RESULTS-1:0][7:0] t_bytes;

    // All bytes one command produces; entry 0 goes out first.
    typedef struct packed {
        t_bytes           bytes;
        logic [CNT_W-1:0] count;
        logic             end_last;
        logic             error;
    } t_bundle;

    typedef struct packed {
        logic busy;
        logic free;
    } t_shift_stat;

endpackage
`default_nettype wire

/* src/scpf_cmd_if.sv */
// Command channel: valid/ready with one command per transaction.
`default_nettype none
interface scpf_cmd_if
    import scpf_pkg::*;
();
    logic valid;
    logic ready;
    t_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/scpf_byte_if.sv */
// Byte channel: valid/ready with one framed byte per transaction.
`default_nettype none
interface scpf_byte_if
    import scpf_pkg::*;
();
    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/scpf_in_stage.sv */
// Input register for commands.
`default_nettype none
module scpf_in_stage
    import scpf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_cmd i_cmd,
    output logic      o_ready,
    input  wire logic i_take,
    output logic      o_valid,
    output t_cmd      o_cmd
);
    logic r_valid;
    t_cmd r_cmd;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= i_cmd;
        end
    end
endmodule
`default_nettype wire

/* src/scpf_frame_calc.sv */
// Packet state and the per-command byte computation.
`default_nettype none
module scpf_frame_calc
    import scpf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_take,
    output t_bundle   o_bundle
);
    logic       r_in_packet, n_in_packet;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_next_id, n_next_id;
    logic [7:0] r_per_entry, n_per_entry;
    logic [7:0] r_left, n_left;
    logic [7:0] r_entries, n_entries;

    logic       w_need_id;
    logic [7:0] w_x1, w_x2, w_hdr_x;
    logic [7:0] w_left1, w_left2, w_entries_dec;
    logic       w_done;

    always_comb begin
        n_in_packet = r_in_packet;
        n_xor       = r_xor;
        n_next_id   = r_next_id;
        n_per_entry = r_per_entry;
        n_left      = r_left;
        n_entries   = r_entries;
        o_bundle    = '0;

        w_hdr_x = i_cmd.packet_id ^ i_cmd.flags ^ i_cmd.address
                ^ i_cmd.length_byte ^ i_cmd.servo_count;
        w_need_id     = (r_left == 8'd0);
        w_x1          = w_need_id ? (r_xor ^ r_next_id) : r_xor;
        w_x2          = w_x1 ^ i_cmd.data_byte;
        w_left1       = w_need_id ? r_per_entry : r_left;
        w_left2       = w_left1 - 8'd1;
        w_entries_dec = r_entries - 8'd1;
        w_done        = (w_left2 == 8'd0) && (w_entries_dec == 8'd0);

        if (i_cmd.op == OP_START) begin
            if (i_cmd.servo_count != 8'd0 && i_cmd.length_byte <= 8'd1) begin
                o_bundle.count = CNT_W'(1);
                o_bundle.error = 1'b1;
                n_in_packet    = 1'b0;
            end else begin
                o_bundle.bytes[0] = HDR_FIRST;
                o_bundle.bytes[1] = HDR_SECOND;
                o_bundle.bytes[2] = i_cmd.packet_id;
                o_bundle.bytes[3] = i_cmd.flags;
                o_bundle.bytes[4] = i_cmd.address;
                o_bundle.bytes[5] = i_cmd.length_byte;
                o_bundle.bytes[6] = i_cmd.servo_count;
                n_xor     = w_hdr_x;
                n_next_id = i_cmd.first_id;
                n_left    = 8'd0;
                if (i_cmd.servo_count == 8'd0) begin
                    // short request: checksum right after the header
                    o_bundle.bytes[7] = w_hdr_x;
                    o_bundle.count    = CNT_W'(8);
                    o_bundle.end_last = 1'b1;
                    n_in_packet       = 1'b0;
                    n_entries         = 8'd0;
                    n_per_entry       = 8'd0;
                end else begin
                    o_bundle.count = CNT_W'(7);
                    n_in_packet    = 1'b1;
                    n_entries      = i_cmd.servo_count;
                    n_per_entry    = i_cmd.length_byte - 8'd1;
                end
            end
        end else if (!r_in_packet) begin
            o_bundle.count = CNT_W'(1);
            o_bundle.error = 1'b1;
        end else begin
            o_bundle.bytes[0] = w_need_id ? r_next_id : i_cmd.data_byte;
            o_bundle.bytes[1] = w_need_id ? i_cmd.data_byte : w_x2;
            o_bundle.bytes[2] = w_x2;
            o_bundle.count    = CNT_W'({1'b0, w_need_id} + {1'b0, 1'b1} + {1'b0, w_done});
            o_bundle.end_last = w_done;
            n_xor       = w_x2;
            n_left      = w_left2;
            n_in_packet = !w_done;
            if (w_need_id) begin
                n_next_id = r_next_id + 8'd1;
            end
            if (w_left2 == 8'd0) begin
                n_entries = w_entries_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_xor       <= 8'd0;
            r_next_id   <= 8'd0;
            r_per_entry <= 8'd0;
            r_left      <= 8'd0;
            r_entries   <= 8'd0;
        end else if (i_take) begin
            r_in_packet <= n_in_packet;
            r_xor       <= n_xor;
            r_next_id   <= n_next_id;
            r_per_entry <= n_per_entry;
            r_left      <= n_left;
            r_entries   <= n_entries;
        end
    end
endmodule
`default_nettype wire

/* src/scpf_out_shift.sv */
// Result register that shifts a command's bytes out one per transaction.
`default_nettype none
module scpf_out_shift
    import scpf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_bundle i_bundle,
    output t_shift_stat  o_stat,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_res         o_res
);
    t_bytes           r_bytes, n_bytes;
    logic [CNT_W-1:0] r_cnt;
    logic             r_end_last;
    logic             r_error;
    logic             w_pop;

    assign o_valid       = (r_cnt != '0);
    assign w_pop         = o_valid && i_ready;
    assign o_stat.busy   = o_valid;
    // free when empty, or when the final byte leaves this cycle
    assign o_stat.free   = !o_valid || (w_pop && r_cnt == CNT_W'(1));
    assign o_res.out_byte = r_error ? 8'd0 : r_bytes[0];
    assign o_res.last     = r_end_last && (r_cnt == CNT_W'(1));
    assign o_res.error    = r_error;

    always_comb begin
        n_bytes = '0;
        for (int k = 0; k < MAX_RESULTS - 1; k++) begin
            n_bytes[k] = r_bytes[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_bundle.count;
        end else if (w_pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes    <= i_bundle.bytes;
            r_end_last <= i_bundle.end_last;
            r_error    <= i_bundle.error;
        end else if (w_pop) begin
            r_bytes <= n_bytes;
        end
    end
endmodule
`default_nettype wire

/* src/servo_command_packet_framer.sv */
// Top level of the servo command packet framer.
//
//   port    dir   carries
//   i_cmd   in    op, packet_id, flags, address, length_byte, servo_count, first_id, data_byte
//   o_res   out   out_byte, last, error (one byte per transaction)
//
// A command waits in the input register until the shift register is free, then its
// bytes (1 to 8) load into the shift register and go out one per transaction:
// 7 or 8 for a start, 1 to 3 for a data byte, 1 for a rejected command.
// The output shift register sets the rate; the next command is computed while
// the last byte of the previous one is handed off.
// Reset (i_rst_n low, synchronous) empties both registers and closes any packet.
// Output stalls back up into the input register, then into i_cmd.ready.
`default_nettype none
`include "assert_macros.svh"
module servo_command_packet_framer
    import scpf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    scpf_cmd_if.sink    i_cmd,
    scpf_byte_if.source o_res
);
    logic        w_in_valid;
    t_cmd        w_cmd;
    logic        w_load;
    t_bundle     w_bundle;
    t_shift_stat w_stat;

    assign w_load = w_in_valid && w_stat.free;

    scpf_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .i_cmd   (i_cmd.payload),
        .o_ready (i_cmd.ready),
        .i_take  (w_load),
        .o_valid (w_in_valid),
        .o_cmd   (w_cmd)
    );

    scpf_frame_calc u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_take   (w_load),
        .o_bundle (w_bundle)
    );

    scpf_out_shift u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_bundle (w_bundle),
        .o_stat   (w_stat),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_res    (o_res.payload)
    );

    `ASSERT_IMPLIES(a_load_free, i_clk, i_rst_n, w_load, !w_stat.busy || o_res.ready, "load while output byte stalled")
    `ASSERT_IMPLIES(a_err_clean, i_clk, i_rst_n, o_res.valid && o_res.payload.error, o_res.payload.out_byte == 8'd0 && !o_res.payload.last, "error transaction carries data")
    `ASSERT_IMPLIES(a_in_ready, i_clk, i_rst_n, !w_in_valid, i_cmd.ready, "empty input register not ready")
    `ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_load, o_res.valid, "loaded command produced no output")
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the servo command packet framer.
`timescale 1ns / 1ps
module tb_top
    import scpf_pkg::*;
;

    localparam int RANDOM_ITEMS = 420;
    localparam int QUIET_TAIL   = 50;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    // Tracks the open packet and holds the bytes the framer still owes.
    class framer_scoreboard;
        logic       in_packet;
        logic [7:0] xor_sum;
        logic [7:0] servo_id;
        logic [7:0] entry_len;
        logic [7:0] entry_left;
        logic [7:0] servos_left;
        t_res       expected_bytes[$];
        int         mismatches;
        int         bytes_checked;
        int         rejects;
        int         packets_closed;

        function new();
            in_packet      = 1'b0;
            xor_sum        = '0;
            servo_id       = '0;
            entry_len      = '0;
            entry_left     = '0;
            servos_left    = '0;
            mismatches     = 0;
            bytes_checked  = 0;
            rejects        = 0;
            packets_closed = 0;
        endfunction

        function void push_byte(input logic [7:0] b, input logic is_last);
            t_res r;
            r.out_byte = b;
            r.last     = is_last;
            r.error    = 1'b0;
            expected_bytes.push_back(r);
            if (is_last) packets_closed++;
        endfunction

        function void push_summed(input logic [7:0] b);
            xor_sum = xor_sum ^ b;
            push_byte(b, 1'b0);
        endfunction

        function void push_reject();
            t_res r;
            r.out_byte = '0;
            r.last     = 1'b0;
            r.error    = 1'b1;
            expected_bytes.push_back(r);
            rejects++;
        endfunction

        // Predicts the framed bytes for one accepted command.
        function void predict_frame_bytes(input t_cmd c);
            if (c.op == OP_START) begin
                if (c.servo_count != 8'd0 && c.length_byte <= 8'd1) begin
                    in_packet = 1'b0;
                    push_reject();
                    return;
                end
                push_byte(HDR_FIRST, 1'b0);
                push_byte(HDR_SECOND, 1'b0);
                xor_sum = '0;
                push_summed(c.packet_id);
                push_summed(c.flags);
                push_summed(c.address);
                push_summed(c.length_byte);
                push_summed(c.servo_count);
                servo_id   = c.first_id;
                entry_left = '0;
                if (c.servo_count == 8'd0) begin
                    push_byte(xor_sum, 1'b1);
                    in_packet   = 1'b0;
                    servos_left = '0;
                    entry_len   = '0;
                end else begin
                    in_packet   = 1'b1;
                    servos_left = c.servo_count;
                    entry_len   = c.length_byte - 8'd1;
                end
                return;
            end
            if (!in_packet) begin
                push_reject();
                return;
            end
            // entry_left of zero means this entry still needs its servo id
            if (entry_left == 8'd0) begin
                push_summed(servo_id);
                servo_id   = servo_id + 8'd1;
                entry_left = entry_len;
            end
            push_summed(c.data_byte);
            entry_left = entry_left - 8'd1;
            if (entry_left == 8'd0) begin
                servos_left = servos_left - 8'd1;
                if (servos_left == 8'd0) begin
                    push_byte(xor_sum, 1'b1);
                    in_packet = 1'b0;
                end
            end
        endfunction

        function void check_byte(input t_res got);
            t_res want;
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected byte %02h last=%0b err=%0b at %0t",
                             got.out_byte, got.last, got.error, $realtime);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.last !== want.last
                    || got.error !== want.error) begin
                mismatches++;
                if (mismatches <= 10)
                    $display(
                        "ERROR: byte #%0d expected %02h last=%0b err=%0b, got %02h last=%0b err=%0b",
                        bytes_checked, want.out_byte, want.last, want.error,
                        got.out_byte, got.last, got.error);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    bit   hold_output;
    int   n_items;
    int   n_data_items;
    int   cycles;

    framer_scoreboard sb;

    scpf_cmd_if  cmd_ch ();
    scpf_byte_if res_ch ();

    servo_command_packet_framer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes outstanding",
                     cycles, sb.expected_bytes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output side: sampled at the falling edge, so the values are settled
    // for the rising edge that completes the transaction.
    always @(negedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_byte(res_ch.payload);
    end

    initial begin : res_sink
        int stall;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_output = 1'b0;
                res_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 19);
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                res_ch.ready <= 1'b1;
                // sometimes follow with a clean stretch
                if ($urandom_range(0, 1) == 0)
                    repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    function automatic t_cmd random_command(input t_op op);
        t_cmd c;
        c.op          = op;
        c.packet_id   = 8'($urandom_range(0, 255));
        c.flags       = 8'($urandom_range(0, 255));
        c.address     = 8'($urandom_range(0, 255));
        c.length_byte = 8'($urandom_range(0, 255));
        c.servo_count = 8'($urandom_range(0, 255));
        c.first_id    = 8'($urandom_range(0, 255));
        c.data_byte   = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Entered and left at a rising edge; valid stays high between
    // back-to-back commands.
    task automatic issue(input t_cmd c);
        bit taken;
        if (!quiet && !hold_output && $urandom_range(0, 5) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= c;
        do begin
            @(negedge i_clk);
            taken = cmd_ch.ready;
            if (taken) sb.predict_frame_bytes(c);
            @(posedge i_clk);
        end while (!taken);
        n_items++;
        if (c.op == OP_DATA) n_data_items++;
    endtask

    task automatic send_packet(input t_cmd start, input int n_data);
        issue(start);
        repeat (n_data) issue(random_command(OP_DATA));
    endtask

    initial begin : stimulus
        t_cmd c;
        int   cnt;
        int   len;
        int   total;
        int   n_data;
        int   r;
        int   random_end;
        sb             = new();
        quiet          = 1'b0;
        hold_output    = 1'b0;
        n_items        = 0;
        n_data_items   = 0;
        cycles         = 0;
        i_rst_n        = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // data with no open packet is rejected
        c = random_command(OP_DATA);
        c.data_byte = 8'hFF;
        issue(c);
        // request packets: no entries, checksum right after the header
        c = '0;
        c.op = OP_START;
        issue(c);
        c = '1;
        c.op = OP_START;
        c.servo_count = 8'd0;
        issue(c);
        // entries with no payload are rejected
        c = random_command(OP_START);
        c.servo_count = 8'd1;
        c.length_byte = 8'd0;
        issue(c);
        c = random_command(OP_START);
        c.servo_count = 8'hFF;
        c.length_byte = 8'd1;
        issue(c);
        issue(random_command(OP_DATA));
        // servo id wraps from 255 to 0
        c = random_command(OP_START);
        c.servo_count = 8'd2;
        c.length_byte = 8'd2;
        c.first_id    = 8'hFF;
        send_packet(c, 2);
        // payload byte extremes
        c = random_command(OP_START);
        c.servo_count = 8'd1;
        c.length_byte = 8'd4;
        issue(c);
        c = random_command(OP_DATA);
        c.data_byte = 8'h00;
        issue(c);
        c.data_byte = 8'hFF;
        issue(c);
        c.data_byte = 8'h5A;
        issue(c);
        // a new start abandons the open packet
        c = random_command(OP_START);
        c.servo_count = 8'd3;
        c.length_byte = 8'd3;
        send_packet(c, 2);
        c = random_command(OP_START);
        c.servo_count = 8'd1;
        c.length_byte = 8'd2;
        send_packet(c, 1);
        issue(random_command(OP_DATA));

        // output stalls for a long time while commands keep coming
        hold_output = 1'b1;
        random_end = n_items + RANDOM_ITEMS;
        while (n_items < random_end) begin
            if (n_items >= random_end - QUIET_TAIL) quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                c   = random_command(OP_START);
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(1, 4);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(2, 5);
                c.servo_count = cnt[7:0];
                c.length_byte = len[7:0];
                total = (cnt == 0 || len <= 1) ? 0 : cnt * (len - 1);
                if (total > 40)
                    n_data = $urandom_range(1, 30);
                else if (total > 0 && $urandom_range(0, 9) == 0)
                    n_data = $urandom_range(0, total - 1);
                else
                    n_data = total;
                send_packet(c, n_data);
            end else if (r < 85) begin
                repeat ($urandom_range(1, 3)) issue(random_command(OP_DATA));
            end else begin
                send_packet(random_command(OP_START), $urandom_range(0, 4));
            end
        end
        cmd_ch.valid <= 1'b0;

        while (sb.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands (%0d payload bytes); checked %0d output bytes,",
                 n_items, n_data_items, sb.bytes_checked);
        $display("including %0d rejections and %0d completed packets.",
                 sb.rejects, sb.packets_closed);
        if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
